// ===== design/bedq_pkg.sv =====
// shared constants, types and helper functions of the band energy dequantizer
package bedq_pkg;

  localparam int BANDS    = 21;
  localparam int CHANNELS = 2;
  localparam int DEPTH    = BANDS * CHANNELS;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int E_W      = 24;
  localparam int SUM_W    = 28;

  localparam int E_FLOOR    = -9216;
  localparam int BETA_INTRA = 4915;
  localparam int E_MAX      = 8388607;
  localparam int E_MIN      = -8388608;

  typedef logic signed [E_W-1:0] energy_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [14:0]           coef_t;

  typedef struct packed {
    logic [1:0] frame_size_code;
    logic       intra_mode;
  } bedq_cfg_t;

  typedef struct packed {
    logic              kind;
    logic signed [7:0] coarse_index;
    logic [3:0]        fine_bits;
    logic [7:0]        fine_value;
  } bedq_item_t;

  localparam logic KIND_COARSE = 1'b0;
  localparam logic KIND_FINE   = 1'b1;

  function automatic coef_t pred_coef(input logic [1:0] code);
    coef_t c;
    case (code)
      2'd0:    c = 15'd29440;
      2'd1:    c = 15'd26112;
      2'd2:    c = 15'd21248;
      default: c = 15'd16384;
    endcase
    return c;
  endfunction

  function automatic coef_t beta_coef(input logic [1:0] code);
    coef_t c;
    case (code)
      2'd0:    c = 15'd30147;
      2'd1:    c = 15'd22282;
      2'd2:    c = 15'd12124;
      default: c = 15'd6554;
    endcase
    return c;
  endfunction

  function automatic energy_t sat_energy(input logic signed [SUM_W-1:0] x);
    energy_t r;
    if (x > SUM_W'(E_MAX)) begin
      r = energy_t'(E_MAX);
    end else if (x < SUM_W'(E_MIN)) begin
      r = energy_t'(E_MIN);
    end else begin
      r = x[E_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/bedq_ram.sv =====
// generic single write port ram with registered read
module bedq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 42
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bedq_update.sv =====
// coarse and fine energy update arithmetic for one item
module bedq_update (
  input  bedq_pkg::bedq_item_t item,
  input  bedq_pkg::bedq_cfg_t  cfg,
  input  bedq_pkg::energy_t    e_cur,
  input  bedq_pkg::energy_t    carry_cur,
  output bedq_pkg::energy_t    e_new,
  output bedq_pkg::energy_t    carry_new
);

  bedq_pkg::coef_t           coef;
  bedq_pkg::coef_t           beta;
  bedq_pkg::energy_t         e_fl;
  logic signed [17:0]        q;
  logic signed [39:0]        pred_p;
  logic signed [39:0]        pred_b;
  logic signed [24:0]        pred_r;
  logic signed [33:0]        leak_p;
  logic signed [33:0]        leak_b;
  logic signed [18:0]        leak_r;
  logic signed [bedq_pkg::SUM_W-1:0] e_sum;
  logic signed [bedq_pkg::SUM_W-1:0] c_sum;
  logic [3:0]                b_eff;
  logic [3:0]                sh;
  logic [7:0]                v_m;
  logic [9:0]                odd;
  logic [9:0]                off_u;
  logic signed [10:0]        off;
  logic signed [bedq_pkg::SUM_W-1:0] f_sum;

  always_comb begin
    coef = cfg.intra_mode ? '0 : bedq_pkg::pred_coef(cfg.frame_size_code);
    beta = cfg.intra_mode ? bedq_pkg::coef_t'(bedq_pkg::BETA_INTRA)
                          : bedq_pkg::beta_coef(cfg.frame_size_code);

    // coarse path: floor, predict, add carry and index
    e_fl   = (e_cur < bedq_pkg::energy_t'(bedq_pkg::E_FLOOR))
             ? bedq_pkg::energy_t'(bedq_pkg::E_FLOOR) : e_cur;
    q      = signed'({item.coarse_index, 10'b0});
    pred_p = signed'({1'b0, coef}) * e_fl;
    pred_b = pred_p + 40'sd16384;
    pred_r = pred_b[39:15];
    e_sum  = bedq_pkg::SUM_W'(pred_r) + bedq_pkg::SUM_W'(carry_cur)
           + bedq_pkg::SUM_W'(q);

    // carry leak
    leak_p = signed'({1'b0, beta}) * q;
    leak_b = leak_p + 34'sd16384;
    leak_r = leak_b[33:15];
    c_sum  = bedq_pkg::SUM_W'(carry_cur) + bedq_pkg::SUM_W'(q)
           - bedq_pkg::SUM_W'(leak_r);

    // fine path: offset (2v+1) << (9-b) minus one half
    b_eff = (item.fine_bits > 4'd8) ? 4'd8 : item.fine_bits;
    v_m   = item.fine_value & 8'((9'd1 << b_eff) - 9'd1);
    sh    = 4'd9 - b_eff;
    odd   = {1'b0, v_m, 1'b1};
    off_u = odd << sh;
    off   = signed'({1'b0, off_u}) - 11'sd512;
    f_sum = bedq_pkg::SUM_W'(e_cur) + bedq_pkg::SUM_W'(off);

    if (item.kind == bedq_pkg::KIND_COARSE) begin
      e_new = bedq_pkg::sat_energy(e_sum);
    end else if (item.fine_bits == 4'd0) begin
      e_new = e_cur;
    end else begin
      e_new = bedq_pkg::sat_energy(f_sum);
    end
    carry_new = bedq_pkg::sat_energy(c_sum);
  end

endmodule

// ===== design/band_energy_dequantizer_unit.sv =====
// top level of the band energy dequantizer: handshake, energy store, carries
//
// rebuilds per-band q10 log2 energies from decoded coarse and fine indices.
// one beat per clock sustained while the result channel is drained: an item
// accepted from the input ports is held in the stage one register, where the
// energy store's registered read (address from the input ports at accept)
// lines up with it while its update is computed and written back; its result
// then moves to the output register once that is free or being drained. a
// one-entry bypass of the last write covers back-to-back hits on the same
// band and channel. the store comes out of reset cleared through one valid
// bit per entry, so no clearing pass is needed and items are taken right
// after reset. an item with band or channel out of range only applies its
// frame start clear and reports energy zero. configuration is written
// through cfg_we / cfg_index / cfg_data and applies to the item in stage one after the write.
module band_energy_dequantizer_unit (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic              frame_start,
  input  logic [4:0]        band,
  input  logic              channel,
  input  logic signed [7:0] coarse_index,
  input  logic [3:0]        fine_bits,
  input  logic [7:0]        fine_value,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [23:0] energy,
  output logic [4:0]        band_out,
  output logic              channel_out
);

  // register indexes
  localparam logic CFG_FRAME_SIZE = 1'b0;
  localparam logic CFG_INTRA      = 1'b1;

  bedq_pkg::bedq_cfg_t cfg;

  // handshake
  logic accept;
  logic s1_adv;
  logic s1_fire;

  // input register stage
  logic                 s1_valid;
  bedq_pkg::bedq_item_t s1_item;
  logic                 s1_frame_start;
  logic [4:0]           s1_band;
  logic                 s1_channel;
  bedq_pkg::idx_t       s1_idx;
  logic                 s1_in_range;

  bedq_pkg::idx_t       in_idx;
  logic                 in_range;

  // energy store, valid bits and last-write bypass
  logic [bedq_pkg::DEPTH-1:0] valid_bits;
  logic [bedq_pkg::E_W-1:0]   ram_rdata;
  logic                       byp_valid;
  bedq_pkg::idx_t             byp_idx;
  bedq_pkg::energy_t          byp_data;
  bedq_pkg::energy_t          e_cur;

  // carries
  bedq_pkg::energy_t carry [2];
  bedq_pkg::energy_t carry_cur;
  bedq_pkg::energy_t e_new;
  bedq_pkg::energy_t carry_new;
  logic              ram_we;

  // configuration decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_SIZE: cfg.frame_size_code <= cfg_data;
        CFG_INTRA:      cfg.intra_mode      <= cfg_data[0];
      endcase
    end
  end

  // stage advances when the result register is free or being drained
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign s1_fire  = s1_valid && s1_adv;

  // store index of the incoming beat
  assign in_range = (int'(band) < bedq_pkg::BANDS) && (int'(channel) < bedq_pkg::CHANNELS);
  assign in_idx   = bedq_pkg::idx_t'(int'(band) + int'(channel) * bedq_pkg::BANDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.kind         <= kind;
      s1_item.coarse_index <= coarse_index;
      s1_item.fine_bits    <= fine_bits;
      s1_item.fine_value   <= fine_value;
      s1_frame_start       <= frame_start;
      s1_band              <= band;
      s1_channel           <= channel;
      s1_idx               <= in_idx;
      s1_in_range          <= in_range;
    end
  end

  // read issued at accept, data lines up with the beat in stage one
  assign ram_we = s1_fire && s1_in_range;

  bedq_ram #(
    .WIDTH (bedq_pkg::E_W),
    .DEPTH (bedq_pkg::DEPTH)
  ) u_energy_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (e_new),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // stored energy: last write wins over the ram word, unwritten reads zero
  always_comb begin
    if (byp_valid && (byp_idx == s1_idx)) begin
      e_cur = byp_data;
    end else if (valid_bits[s1_idx]) begin
      e_cur = signed'(ram_rdata);
    end else begin
      e_cur = '0;
    end
    carry_cur = s1_frame_start ? '0 : carry[s1_channel];
  end

  bedq_update u_update (
    .item      (s1_item),
    .cfg       (cfg),
    .e_cur     (e_cur),
    .carry_cur (carry_cur),
    .e_new     (e_new),
    .carry_new (carry_new)
  );

  // write back: valid bit, bypass entry, carries
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      byp_valid  <= 1'b0;
      carry[0]   <= '0;
      carry[1]   <= '0;
    end else if (s1_fire) begin
      if (s1_in_range) begin
        valid_bits[s1_idx] <= 1'b1;
        byp_valid          <= 1'b1;
      end
      // in-range coarse beat writes its own carry; frame start clears the rest
      if (s1_in_range && (s1_item.kind == bedq_pkg::KIND_COARSE)) begin
        carry[s1_channel] <= carry_new;
        if (s1_frame_start) begin
          carry[!s1_channel] <= '0;
        end
      end else if (s1_frame_start) begin
        carry[0] <= '0;
        carry[1] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_idx  <= s1_idx;
      byp_data <= e_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      energy      <= s1_in_range ? e_new : '0;
      band_out    <= s1_band;
      channel_out <= s1_channel;
    end
  end

  // stall only comes from a full, undrained result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // a written entry is marked valid afterwards
  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid_bits[$past(s1_idx)])
    else $error("written entry not marked valid");

  // out of range bands report zero energy
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (int'(band_out) >= bedq_pkg::BANDS)) |-> (energy == '0))
    else $error("out of range band reported nonzero energy");

  // frame start leaves the other channel's carry cleared
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_frame_start) |=> (carry[!$past(s1_channel)] == '0))
    else $error("frame start did not clear the other carry");

  // bypass always mirrors the last write
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (byp_valid && (byp_data == $past(e_new))))
    else $error("bypass entry does not hold the last write");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the band energy dequantizer unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bedq_pkg::*;

  // register indexes of the configuration port
  localparam logic REG_FRAME_SIZE = 1'b0;
  localparam logic REG_INTRA_MODE = 1'b1;

  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 135;
  localparam int SETTLE_CYCLES = 6;     // margin after the last expected update is back
  localparam int STALL_LIMIT   = 5000;  // no beat on either side for this long

  typedef struct packed {
    logic              kind;
    logic              frame_start;
    logic [4:0]        band;
    logic              channel;
    logic signed [7:0] coarse_index;
    logic [3:0]        fine_bits;
    logic [7:0]        fine_value;
  } band_item_t;

  typedef struct packed {
    energy_t    energy;
    logic [4:0] band;
    logic       channel;
  } band_update_t;

  typedef struct packed {
    band_item_t item;
    logic       known;    // energy below is typed in, otherwise predicted
    energy_t    want;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_FRAME_SIZE;
  logic [1:0]        cfg_data = 2'd0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_COARSE;
  logic              frame_start = 1'b0;
  logic [4:0]        band = 5'd0;
  logic              channel = 1'b0;
  logic signed [7:0] coarse_index = 8'sd0;
  logic [3:0]        fine_bits = 4'd0;
  logic [7:0]        fine_value = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [23:0] energy;
  logic [4:0]        band_out;
  logic              channel_out;

  band_energy_dequantizer_unit dut (.*);

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // energy predictor: its own copy of the store, the carries and the registers
  // ---------------------------------------------------------------------------
  longint     energy_store [DEPTH];
  longint     carry [2];
  logic [1:0] frame_code = 2'd0;
  logic       intra_on = 1'b0;

  band_update_t pending_energies [$];
  int           error_count = 0;
  bit           steady = 1'b0;   // no sender gaps while set

  function automatic longint sat24(input longint x);
    if (x > E_MAX) return E_MAX;
    if (x < E_MIN) return E_MIN;
    return x;
  endfunction

  // divide by 2^15, round to nearest with ties up (floor of x + half)
  function automatic longint round_q15(input longint x);
    return (x + 64'sd16384) >>> 15;
  endfunction

  function automatic longint pred_q15(input logic [1:0] code);
    case (code)
      2'd0:    return 29440;
      2'd1:    return 26112;
      2'd2:    return 21248;
      default: return 16384;
    endcase
  endfunction

  function automatic longint leak_q15(input logic [1:0] code);
    case (code)
      2'd0:    return 30147;
      2'd1:    return 22282;
      2'd2:    return 12124;
      default: return 6554;
    endcase
  endfunction

  task automatic dequantize(input band_item_t it, output band_update_t upd);
    longint e, q, c, coef, leak, mask, off;
    int     idx, bits;
    upd.energy  = '0;
    upd.band    = it.band;
    upd.channel = it.channel;
    // frame start clears both carries even when the band is out of range
    if (it.frame_start) begin
      carry[0] = 0;
      carry[1] = 0;
    end
    if (it.band < BANDS && it.channel < CHANNELS) begin
      idx = it.band + it.channel * BANDS;
      e   = energy_store[idx];
      if (it.kind == KIND_COARSE) begin
        coef = intra_on ? 0 : pred_q15(frame_code);
        leak = intra_on ? BETA_INTRA : leak_q15(frame_code);
        q    = longint'(it.coarse_index) * 1024;
        c    = carry[it.channel];
        if (e < E_FLOOR) e = E_FLOOR;
        e = sat24(round_q15(coef * e) + c + q);
        carry[it.channel] = sat24(c + q - round_q15(leak * q));
      end else if (it.fine_bits != 0) begin
        // more than eight fine bits act as eight
        bits = (it.fine_bits > 8) ? 8 : it.fine_bits;
        mask = (64'sd1 << bits) - 1;
        off  = ((2 * (longint'(it.fine_value) & mask) + 1) << (9 - bits)) - 512;
        e    = sat24(e + off);
      end
      energy_store[idx] = e;
      upd.energy = energy_t'(e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  // small indices most of the time, with extremes and full range mixed in
  function automatic logic signed [7:0] rand_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'(int'($urandom_range(0, 8)) - 4);
    if (r == 5) return 8'sd127;
    if (r == 6) return 8'sh80;
    return 8'($urandom);
  endfunction

  // present one beat, hold it until taken, then predict its update
  task automatic send_beat(input band_item_t it, input logic known, input energy_t want);
    int           gap;
    band_update_t upd;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind         <= it.kind;
    frame_start  <= it.frame_start;
    band         <= it.band;
    channel      <= it.channel;
    coarse_index <= it.coarse_index;
    fine_bits    <= it.fine_bits;
    fine_value   <= it.fine_value;
    in_valid     <= 1'b1;
    // handshake inputs only move at rising edges, so the falling edge sees
    // what the next rising edge will sample
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    dequantize(it, upd);
    if (known) upd.energy = want;
    pending_energies.push_back(upd);
  endtask

  task automatic wait_for_drain();
    while (pending_energies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    if (index == REG_FRAME_SIZE) frame_code = value;
    else intra_on = value[0];
  endtask

  // ---------------------------------------------------------------------------
  // directed table, run with the reset configuration
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [0:15] = '{
    // zero fine bits right after reset report the cleared store
    '{'{KIND_FINE,   1'b0, 5'd0,  1'b0, 8'sd0,   4'd0,  8'd0},   1'b1, 24'sd0},
    // top band, largest index
    '{'{KIND_COARSE, 1'b1, 5'd20, 1'b1, 8'sd127, 4'd0,  8'd0},   1'b1, 24'sd130048},
    // smallest index with carries cleared
    '{'{KIND_COARSE, 1'b1, 5'd1,  1'b1, 8'sh80,  4'd0,  8'd0},   1'b1, -24'sd131072},
    // eight fine bits, largest value
    '{'{KIND_FINE,   1'b0, 5'd2,  1'b0, 8'sd0,   4'd8,  8'd255}, 1'b1, 24'sd510},
    // fine bits above eight act as eight
    '{'{KIND_FINE,   1'b0, 5'd3,  1'b0, 8'sd0,   4'd15, 8'd255}, 1'b1, 24'sd510},
    '{'{KIND_FINE,   1'b0, 5'd4,  1'b0, 8'sd0,   4'd1,  8'd0},   1'b1, -24'sd256},
    // value masked down to one bit
    '{'{KIND_FINE,   1'b0, 5'd4,  1'b0, 8'sd0,   4'd1,  8'd255}, 1'b1, 24'sd0},
    // bands past the last one report zero
    '{'{KIND_COARSE, 1'b1, 5'd21, 1'b0, 8'sd127, 4'd0,  8'd0},   1'b1, 24'sd0},
    '{'{KIND_FINE,   1'b0, 5'd31, 1'b1, 8'sd0,   4'd8,  8'd255}, 1'b1, 24'sd0},
    '{'{KIND_COARSE, 1'b1, 5'd5,  1'b0, 8'sh80,  4'd0,  8'd0},   1'b1, -24'sd131072},
    // same band back to back: stored energy clamped at the floor first
    '{'{KIND_COARSE, 1'b1, 5'd5,  1'b0, 8'sd0,   4'd0,  8'd0},   1'b1, -24'sd8280},
    '{'{KIND_COARSE, 1'b0, 5'd5,  1'b0, 8'sd3,   4'd0,  8'd0},   1'b0, 24'sd0},
    '{'{KIND_COARSE, 1'b0, 5'd6,  1'b0, 8'shFF,  4'd0,  8'd0},   1'b0, 24'sd0},
    // index field ignored on a fine beat
    '{'{KIND_FINE,   1'b0, 5'd5,  1'b0, 8'shFF,  4'd4,  8'd170}, 1'b0, 24'sd0},
    // fine fields ignored on a coarse beat
    '{'{KIND_COARSE, 1'b0, 5'd20, 1'b1, 8'sd127, 4'd15, 8'd255}, 1'b0, 24'sd0},
    // frame start on a fine beat
    '{'{KIND_FINE,   1'b1, 5'd20, 1'b1, 8'sd0,   4'd8,  8'd0},   1'b0, 24'sd0}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    band_item_t it;
    int         sent, pattern, nb, chans, n, b, ch, bits;
    logic       up;

    foreach (energy_store[i]) energy_store[i] = 0;
    carry[0] = 0;
    carry[1] = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(directed_rows); i++)
      send_beat(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);

    // each phase starts from an idle block: the sender holds off until every
    // expected update is back, then both registers are rewritten
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_for_drain();
      write_reg(REG_FRAME_SIZE, 2'(p % 4));
      write_reg(REG_INTRA_MODE, 2'((p / 4) % 2));
      cfg_we <= 1'b0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        steady  = ($urandom_range(0, 4) == 0);
        pattern = $urandom_range(0, 99);
        if (pattern < 55) begin
          // well-formed frame: coarse pass band by band, then fine pass
          nb    = $urandom_range(1, BANDS);
          chans = $urandom_range(1, CHANNELS);
          for (b = 0; b < nb; b++) begin
            for (ch = 0; ch < chans; ch++) begin
              it.kind         = KIND_COARSE;
              it.frame_start  = (b == 0 && ch == 0);
              it.band         = 5'(b);
              it.channel      = 1'(ch);
              it.coarse_index = rand_index();
              it.fine_bits    = 4'($urandom_range(0, 15));
              it.fine_value   = 8'($urandom);
              send_beat(it, 1'b0, '0);
              sent++;
            end
          end
          for (b = 0; b < nb; b++) begin
            bits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            for (ch = 0; ch < chans; ch++) begin
              it.kind         = KIND_FINE;
              it.frame_start  = 1'b0;
              it.band         = 5'(b);
              it.channel      = 1'(ch);
              it.coarse_index = 8'($urandom);
              it.fine_bits    = 4'(bits);
              it.fine_value   = 8'($urandom);
              send_beat(it, 1'b0, '0);
              sent++;
            end
          end
        end else if (pattern < 72) begin
          // long run with no frame start and mostly one sign of index: drives the
          // carry and the energies into saturation
          n  = $urandom_range(20, 120);
          ch = $urandom_range(0, 1);
          up = 1'($urandom_range(0, 1));
          for (int k = 0; k < n; k++) begin
            it.frame_start  = 1'b0;
            it.band         = 5'($urandom_range(0, BANDS - 1));
            it.channel      = 1'(ch);
            it.coarse_index = ($urandom_range(0, 7) == 0) ? rand_index()
                                                          : (up ? 8'sd127 : 8'sh80);
            it.kind         = ($urandom_range(0, 4) == 0) ? KIND_FINE : KIND_COARSE;
            it.fine_bits    = 4'($urandom_range(1, 2));
            it.fine_value   = up ? 8'd255 : 8'd0;
            send_beat(it, 1'b0, '0);
            sent++;
          end
        end else begin
          // noise: every field over its whole width
          n = $urandom_range(1, 10);
          for (int k = 0; k < n; k++) begin
            it.kind         = 1'($urandom);
            it.frame_start  = ($urandom_range(0, 7) == 0);
            it.band         = 5'($urandom);
            it.channel      = 1'($urandom);
            it.coarse_index = 8'($urandom);
            it.fine_bits    = 4'($urandom);
            it.fine_value   = 8'($urandom);
            send_beat(it, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    wait_for_drain();
    if (error_count == 0) begin
      $display("band_energy_dequantizer_unit regression: pass");
    end else begin
      $display("band_energy_dequantizer_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: stalls of random length between runs of ready
  // ---------------------------------------------------------------------------
  int rx_stall = 0;
  int rx_run   = 0;

  always @(posedge clk) begin
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else if (rx_run > 0) begin
      out_ready <= 1'b1;
      rx_run    <= rx_run - 1;
    end else begin
      // now and then a long stretch with no stall at all
      out_ready <= 1'b1;
      rx_stall  <= pick_gap();
      rx_run    <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 8);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // result beat is taken at the next rising edge; its fields are stable here
  always @(negedge clk) begin
    band_update_t exp_upd;
    if (!rst && out_valid && out_ready) begin
      if (pending_energies.size() == 0) begin
        report_mismatch("unexpected beat", 0, energy);
      end else begin
        exp_upd = pending_energies.pop_front();
        if (energy !== exp_upd.energy)
          report_mismatch("energy", exp_upd.energy, energy);
        if (band_out !== exp_upd.band)
          report_mismatch("band_out", exp_upd.band, band_out);
        if (channel_out !== exp_upd.channel)
          report_mismatch("channel_out", exp_upd.channel, channel_out);
      end
    end
  end

  // watchdog: too long without a beat on either side ends the run
  int idle_cycles = 0;

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("band_energy_dequantizer_unit regression: fail");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
design/bedq_pkg.sv
design/bedq_ram.sv
design/bedq_update.sv
design/band_energy_dequantizer_unit.sv
tb/testbench.sv
